// File: rtl/core/udpb_pkg.sv
// Shared types, codes and reset values of the UDP port bind table.
package udpb_pkg;

  // Default table size
  localparam int TABLE_ENTRIES_DEF = 16;

  // Field widths
  localparam int PORT_W   = 16;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_BIND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PORT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPH_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPH_HIGH = 2'd2;

  // Configuration reset values
  localparam logic [PORT_W-1:0] RESERVED_RST = 16'd68;
  localparam logic [PORT_W-1:0] EPH_LOW_RST  = 16'd32768;
  localparam logic [PORT_W-1:0] EPH_HIGH_RST = 16'd60999;

  // Source of the result slot
  localparam logic [1:0] SLOT_SRC_NONE  = 2'd0;
  localparam logic [1:0] SLOT_SRC_MATCH = 2'd1;
  localparam logic [1:0] SLOT_SRC_FREE  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load_req;
    logic                use_cand;
    logic                alloc_init;
    logic                alloc_step;
    logic                take_cand;
    logic                bind_write;
    logic                close_clear;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic [1:0]          res_slot_src;
    logic                res_port_zero;
  } udpb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              port_zero;
    logic              is_reserved;
    logic              match_hit;
    logic              free_hit;
    logic              cand_over;
    logic              tries_last;
  } udpb_sts_t;

endpackage

// File: rtl/core/udpb_datapath.sv
// Datapath: port table, configuration, request, allocation candidate and result registers.
module udpb_datapath
  import udpb_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_wdata,
  input  logic [MODE_W-1:0]    mode,
  input  logic [PORT_W-1:0]    port,
  input  udpb_cmd_t            cmd,
  output udpb_sts_t            sts,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    slot,
  output logic [PORT_W-1:0]    bound_port
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TRY_W = $clog2(TABLE_ENTRIES + 1) + 1;

  logic [PORT_W-1:0] port_table [TABLE_ENTRIES];
  logic [PORT_W-1:0] reserved_port;
  logic [PORT_W-1:0] eph_low;
  logic [PORT_W-1:0] eph_high;
  logic [MODE_W-1:0] req_mode;
  logic [PORT_W-1:0] req_port;
  logic [PORT_W:0]   cand;
  logic [TRY_W-1:0]  tries;

  logic [PORT_W-1:0] key;
  logic              match_hit;
  logic [IDX_W-1:0]  match_idx;
  logic              free_hit;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  res_idx;
  logic [IDX_W+SLOT_W-1:0] res_idx_ext;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_port <= RESERVED_RST;
      eph_low       <= EPH_LOW_RST;
      eph_high      <= EPH_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESERVED: reserved_port <= cfg_wdata;
        REG_EPH_LOW:  eph_low       <= cfg_wdata;
        REG_EPH_HIGH: eph_high      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture and allocation candidate
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= mode;
      req_port <= port;
    end else if (cmd.take_cand) begin
      req_port <= cand[PORT_W-1:0];
    end
    if (cmd.alloc_init) begin
      cand  <= (eph_low == '0) ? (PORT_W+1)'(1) : {1'b0, eph_low};
      tries <= '0;
    end else if (cmd.alloc_step) begin
      cand  <= cand + 1'b1;
      tries <= tries + 1'b1;
    end
  end

  // Match and free-slot search, lowest slot wins; port 0 never matches
  assign key = cmd.use_cand ? cand[PORT_W-1:0] : req_port;

  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (key != '0 && port_table[i] == key) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (port_table[i] == '0) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        port_table[i] <= '0;
      end
    end else if (cmd.bind_write) begin
      port_table[free_idx] <= req_port;
    end else if (cmd.close_clear) begin
      port_table[match_idx] <= '0;
    end
  end

  // Status to the controller
  assign sts.mode        = req_mode;
  assign sts.port_zero   = (req_port == '0);
  assign sts.is_reserved = (req_port == reserved_port);
  assign sts.match_hit   = match_hit;
  assign sts.free_hit    = free_hit;
  assign sts.cand_over   = (cand > {1'b0, eph_high});
  assign sts.tries_last  = (tries == TRY_W'(TABLE_ENTRIES));

  // Result register
  always_comb begin
    unique case (cmd.res_slot_src)
      SLOT_SRC_MATCH: res_idx = match_idx;
      SLOT_SRC_FREE:  res_idx = free_idx;
      default:        res_idx = '0;
    endcase
  end

  assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status     <= cmd.res_status;
      slot       <= res_idx_ext[SLOT_W-1:0];
      bound_port <= cmd.res_port_zero ? '0 : req_port;
    end
  end

endmodule

// File: rtl/core/udpb_ctrl.sv
// Controller: sequences each request through decode and, for binds, allocation search and bind.
module udpb_ctrl
  import udpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  udpb_sts_t sts,
  output udpb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_BIND  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.mode)
          MODE_BIND: begin
            if (sts.is_reserved) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_RESERVED;
              state_next     = S_DONE;
            end else if (sts.port_zero) begin
              cmd.alloc_init = 1'b1;
              state_next     = S_ALLOC;
            end else begin
              state_next = S_BIND;
            end
          end
          MODE_LOOKUP, MODE_CLOSE: begin
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
            if (sts.match_hit) begin
              cmd.res_status   = ST_OK;
              cmd.res_slot_src = SLOT_SRC_MATCH;
              cmd.close_clear  = (sts.mode == MODE_CLOSE);
            end else begin
              cmd.res_status = ST_NOT_FOUND;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_DONE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd.use_cand = 1'b1;
        priority if (sts.cand_over) begin
          cmd.res_load      = 1'b1;
          cmd.res_status    = ST_NO_PORT;
          cmd.res_port_zero = 1'b1;
          state_next        = S_DONE;
        end else if (!sts.match_hit) begin
          cmd.take_cand = 1'b1;
          state_next    = S_BIND;
        end else if (sts.tries_last) begin
          cmd.res_load      = 1'b1;
          cmd.res_status    = ST_NO_PORT;
          cmd.res_port_zero = 1'b1;
          state_next        = S_DONE;
        end else begin
          cmd.alloc_step = 1'b1;
        end
      end
      S_BIND: begin
        cmd.res_load = 1'b1;
        state_next   = S_DONE;
        priority if (sts.match_hit) begin
          cmd.res_status = ST_BOUND;
        end else if (sts.free_hit) begin
          cmd.bind_write   = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_slot_src = SLOT_SRC_FREE;
        end else begin
          cmd.res_status = ST_FULL;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/udp_port_bind_table.sv
// Top level of the UDP port bind table: controller plus datapath.
// One request (bind, lookup or close) is taken at a time and gives one result
// beat. Lookup, close and reserved refusals go from decode straight to the
// result; an explicit bind passes through the bind step first. An automatic
// bind walks the ephemeral range one candidate per cycle against all slots in
// parallel, at most TABLE_ENTRIES+1 candidates, and moves to the bind step on
// the first free candidate. The next input beat is taken the cycle after the
// result beat leaves. The table is held in flip-flops and cleared by reset;
// no clearing pass.
module udp_port_bind_table
  import udpb_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    mode,
  input  logic [PORT_W-1:0]    port,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    slot,
  output logic [PORT_W-1:0]    bound_port
);

  udpb_cmd_t cmd;
  udpb_sts_t sts;

  // Request sequencer
  udpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table and result registers
  udpb_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .port       (port),
    .cmd        (cmd),
    .sts        (sts),
    .status     (status),
    .slot       (slot),
    .bound_port (bound_port)
  );

endmodule
